FILE: sv/sm83_alu_pkg.sv
`default_nettype none
package sm83_alu_pkg;

  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,
    OP_ADC    = 6'd1,
    OP_SUB    = 6'd2,
    OP_SBC    = 6'd3,
    OP_AND    = 6'd4,
    OP_OR     = 6'd5,
    OP_XOR    = 6'd6,
    OP_CP     = 6'd7,
    OP_INC    = 6'd8,
    OP_DEC    = 6'd9,
    OP_SWAP   = 6'd10,
    OP_DAA    = 6'd11,
    OP_CPL    = 6'd12,
    OP_CCF    = 6'd13,
    OP_SCF    = 6'd14,
    OP_RLCA   = 6'd15,
    OP_RLA    = 6'd16,
    OP_RRCA   = 6'd17,
    OP_RRA    = 6'd18,
    OP_RLC    = 6'd19,
    OP_RL     = 6'd20,
    OP_RRC    = 6'd21,
    OP_RR     = 6'd22,
    OP_SLA    = 6'd23,
    OP_SRA    = 6'd24,
    OP_SRL    = 6'd25,
    OP_BIT    = 6'd26,
    OP_SET    = 6'd27,
    OP_RES    = 6'd28,
    OP_ADD16  = 6'd29,
    OP_ADD_SP = 6'd30,
    OP_INC16  = 6'd31,
    OP_DEC16  = 6'd32
  } alu_op_e;

  localparam logic [7:0] DaaLowAdj  = 8'h06;
  localparam logic [7:0] DaaHighAdj = 8'h60;
  localparam logic [9:0] DaaHighLim = 10'h09F;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        sub_in;
    logic        half_in;
    logic        carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        writes_result;
    logic        zero_out;
    logic        sub_out;
    logic        half_out;
    logic        carry_out;
  } alu_res_t;

endpackage
`default_nettype wire

FILE: sv/sm83_alu_with_flags.sv
`default_nettype none
// Arithmetic and logic unit of an SM83 style 8-bit CPU with the Z, N, H and C flags. Each input
// beat carries an operation, two operands, a bit index and the incoming flags; each output beat
// carries the result, the four new flags and whether the destination is written. An input
// register feeds one pass of combinational logic into a result register, so a beat is accepted
// every cycle while the input is not held back; a beat moves into the result register as soon as
// that register is free and is offered from there until taken. The result register decouples the
// two sides, and a stalled output holds back input only once both registers are full.
module sm83_alu_with_flags
  import sm83_alu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [5:0]  cmd_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  input  wire logic [2:0]  bit_index_i,
  input  wire logic        zero_in_i,
  input  wire logic        sub_in_i,
  input  wire logic        half_in_i,
  input  wire logic        carry_in_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] result_o,
  output      logic        writes_result_o,
  output      logic        zero_out_o,
  output      logic        sub_out_o,
  output      logic        half_out_o,
  output      logic        carry_out_o
);

  alu_req_t req_q;
  alu_req_t req_d;
  alu_res_t res_q;
  alu_res_t res_d;
  logic     req_valid_q;
  logic     req_valid_d;
  logic     res_valid_q;
  logic     res_valid_d;
  logic     res_free;
  logic     in_fire;
  logic     req_move;

  assign res_free   = !res_valid_q || out_ready_i;
  assign req_move   = req_valid_q && res_free;
  assign in_ready_o = !req_valid_q || res_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    req_d.cmd       = cmd_i;
    req_d.operand_a = operand_a_i;
    req_d.operand_b = operand_b_i;
    req_d.bit_index = bit_index_i;
    req_d.zero_in   = zero_in_i;
    req_d.sub_in    = sub_in_i;
    req_d.half_in   = half_in_i;
    req_d.carry_in  = carry_in_i;
  end

  sm83_alu_core u_core (
    .req_i(req_q),
    .res_o(res_d)
  );

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_fire) begin
      req_valid_d = 1'b1;
    end else if (req_move) begin
      req_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (req_move) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
    if (req_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign result_o        = res_q.result;
  assign writes_result_o = res_q.writes_result;
  assign zero_out_o      = res_q.zero_out;
  assign sub_out_o       = res_q.sub_out;
  assign half_out_o      = res_q.half_out;
  assign carry_out_o     = res_q.carry_out;

endmodule
`default_nettype wire

FILE: sv/sm83_alu_core.sv
`default_nettype none
module sm83_alu_core
  import sm83_alu_pkg::*;
(
  input  alu_req_t req_i,
  output alu_res_t res_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] wa;
  logic [15:0] wb;
  logic        cin;
  logic [8:0]  add9;
  logic [8:0]  sub9;
  logic [8:0]  add_cb;
  logic [8:0]  sub_cb;
  logic        daa_lo;
  logic        daa_hi;
  logic [9:0]  daa_t1;
  logic [9:0]  daa_t2;
  logic [7:0]  daa_s1;
  logic [7:0]  daa_s2;
  logic [7:0]  daa_res;
  logic        daa_c;
  logic [16:0] add17;
  logic [16:0] add17_cb;
  logic [15:0] sext;
  logic [15:0] sp_res;
  logic [15:0] sp_cb;
  logic [7:0]  mask;
  logic [7:0]  r8;

  assign a    = req_i.operand_a[7:0];
  assign b    = req_i.operand_b[7:0];
  assign wa   = req_i.operand_a;
  assign wb   = req_i.operand_b;
  assign cin  = ((req_i.cmd == OP_ADC) || (req_i.cmd == OP_SBC)) & req_i.carry_in;
  assign mask = 8'd1 << req_i.bit_index;

  assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign add_cb = {1'b0, a} ^ {1'b0, b} ^ add9;
  assign sub_cb = {1'b0, a} ^ {1'b0, b} ^ sub9;

  assign daa_lo  = req_i.half_in || (a[3:0] > 4'd9);
  assign daa_t1  = {2'b00, a} + (daa_lo ? {2'b00, DaaLowAdj} : 10'd0);
  assign daa_hi  = req_i.carry_in || (daa_t1 > DaaHighLim);
  assign daa_t2  = daa_t1 + (daa_hi ? {2'b00, DaaHighAdj} : 10'd0);
  assign daa_s1  = a - (req_i.half_in ? DaaLowAdj : 8'd0);
  assign daa_s2  = daa_s1 - (req_i.carry_in ? DaaHighAdj : 8'd0);
  assign daa_res = req_i.sub_in ? daa_s2 : daa_t2[7:0];
  assign daa_c   = req_i.carry_in | (~req_i.sub_in & daa_t2[8]);

  assign add17    = {1'b0, wa} + {1'b0, wb};
  assign add17_cb = {1'b0, wa} ^ {1'b0, wb} ^ add17;

  assign sext   = {{8{b[7]}}, b};
  assign sp_res = wa + sext;
  assign sp_cb  = wa ^ sext ^ sp_res;

  always_comb begin
    r8                  = 8'd0;
    res_o.result        = 16'd0;
    res_o.writes_result = 1'b1;
    res_o.zero_out      = req_i.zero_in;
    res_o.sub_out       = req_i.sub_in;
    res_o.half_out      = req_i.half_in;
    res_o.carry_out     = req_i.carry_in;
    case (req_i.cmd)
      OP_ADD, OP_ADC: begin
        r8              = add9[7:0];
        res_o.zero_out  = (r8 == 8'd0);
        res_o.sub_out   = 1'b0;
        res_o.half_out  = add_cb[4];
        res_o.carry_out = add_cb[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8              = sub9[7:0];
        res_o.zero_out  = (r8 == 8'd0);
        res_o.sub_out   = 1'b1;
        res_o.half_out  = sub_cb[4];
        res_o.carry_out = sub_cb[8];
        if (req_i.cmd == OP_CP) begin
          r8                  = 8'd0;
          res_o.writes_result = 1'b0;
        end
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (req_i.cmd == OP_AND) begin
          r8 = a & b;
        end else if (req_i.cmd == OP_OR) begin
          r8 = a | b;
        end else begin
          r8 = a ^ b;
        end
        res_o.zero_out  = (r8 == 8'd0);
        res_o.sub_out   = 1'b0;
        res_o.half_out  = (req_i.cmd == OP_AND);
        res_o.carry_out = 1'b0;
      end
      OP_INC: begin
        r8             = a + 8'd1;
        res_o.zero_out = (r8 == 8'd0);
        res_o.sub_out  = 1'b0;
        res_o.half_out = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r8             = a - 8'd1;
        res_o.zero_out = (r8 == 8'd0);
        res_o.sub_out  = 1'b1;
        res_o.half_out = (a[3:0] == 4'h0);
      end
      OP_SWAP: begin
        r8              = {a[3:0], a[7:4]};
        res_o.zero_out  = (r8 == 8'd0);
        res_o.sub_out   = 1'b0;
        res_o.half_out  = 1'b0;
        res_o.carry_out = 1'b0;
      end
      OP_DAA: begin
        r8              = daa_res;
        res_o.zero_out  = (r8 == 8'd0);
        res_o.half_out  = 1'b0;
        res_o.carry_out = daa_c;
      end
      OP_CPL: begin
        r8             = ~a;
        res_o.sub_out  = 1'b1;
        res_o.half_out = 1'b1;
      end
      OP_CCF, OP_SCF: begin
        res_o.writes_result = 1'b0;
        res_o.sub_out       = 1'b0;
        res_o.half_out      = 1'b0;
        res_o.carry_out     = (req_i.cmd == OP_SCF) | ~req_i.carry_in;
      end
      OP_RLCA, OP_RLC, OP_RLA, OP_RL, OP_SLA: begin
        if ((req_i.cmd == OP_RLCA) || (req_i.cmd == OP_RLC)) begin
          r8 = {a[6:0], a[7]};
        end else if ((req_i.cmd == OP_RLA) || (req_i.cmd == OP_RL)) begin
          r8 = {a[6:0], req_i.carry_in};
        end else begin
          r8 = {a[6:0], 1'b0};
        end
        res_o.carry_out = a[7];
        res_o.zero_out  = (req_i.cmd != OP_RLCA) && (req_i.cmd != OP_RLA) && (r8 == 8'd0);
        res_o.sub_out   = 1'b0;
        res_o.half_out  = 1'b0;
      end
      OP_RRCA, OP_RRC, OP_RRA, OP_RR, OP_SRA, OP_SRL: begin
        if ((req_i.cmd == OP_RRCA) || (req_i.cmd == OP_RRC)) begin
          r8 = {a[0], a[7:1]};
        end else if ((req_i.cmd == OP_RRA) || (req_i.cmd == OP_RR)) begin
          r8 = {req_i.carry_in, a[7:1]};
        end else if (req_i.cmd == OP_SRA) begin
          r8 = {a[7], a[7:1]};
        end else begin
          r8 = {1'b0, a[7:1]};
        end
        res_o.carry_out = a[0];
        res_o.zero_out  = (req_i.cmd != OP_RRCA) && (req_i.cmd != OP_RRA) && (r8 == 8'd0);
        res_o.sub_out   = 1'b0;
        res_o.half_out  = 1'b0;
      end
      OP_BIT: begin
        res_o.writes_result = 1'b0;
        res_o.zero_out      = ((a & mask) == 8'd0);
        res_o.sub_out       = 1'b0;
        res_o.half_out      = 1'b1;
      end
      OP_SET: begin
        r8 = a | mask;
      end
      OP_RES: begin
        r8 = a & ~mask;
      end
      OP_ADD16: begin
        res_o.result    = add17[15:0];
        res_o.sub_out   = 1'b0;
        res_o.half_out  = add17_cb[12];
        res_o.carry_out = add17_cb[16];
      end
      OP_ADD_SP: begin
        res_o.result    = sp_res;
        res_o.zero_out  = 1'b0;
        res_o.sub_out   = 1'b0;
        res_o.half_out  = sp_cb[4];
        res_o.carry_out = sp_cb[8];
      end
      OP_INC16: begin
        res_o.result = wa + 16'd1;
      end
      OP_DEC16: begin
        res_o.result = wa - 16'd1;
      end
      default: begin
        res_o.writes_result = 1'b0;
      end
    endcase
    if ((req_i.cmd != OP_ADD16) && (req_i.cmd != OP_ADD_SP) &&
        (req_i.cmd != OP_INC16) && (req_i.cmd != OP_DEC16)) begin
      res_o.result = {8'd0, r8};
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/sm83_alu_with_flags_tb.sv
`timescale 1ns / 1ps
module sm83_alu_with_flags_tb;
  import sm83_alu_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int LongStall  = 200;
  localparam int DrainTail  = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid  = 1'b0;
  logic     in_ready;
  alu_req_t in_beat   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  alu_res_t out_beat;

  alu_res_t result_q[$];
  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  bit       no_idle        = 1'b0;
  int       stall_req      = 0;
  int       stall_seen     = 0;
  int       stall_left     = 0;

  sm83_alu_with_flags u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (in_beat.cmd),
    .operand_a_i     (in_beat.operand_a),
    .operand_b_i     (in_beat.operand_b),
    .bit_index_i     (in_beat.bit_index),
    .zero_in_i       (in_beat.zero_in),
    .sub_in_i        (in_beat.sub_in),
    .half_in_i       (in_beat.half_in),
    .carry_in_i      (in_beat.carry_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_o        (out_beat.result),
    .writes_result_o (out_beat.writes_result),
    .zero_out_o      (out_beat.zero_out),
    .sub_out_o       (out_beat.sub_out),
    .half_out_o      (out_beat.half_out),
    .carry_out_o     (out_beat.carry_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alu_res_t alu_compute(input alu_req_t r);
    alu_res_t    o;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  mask;
    logic [8:0]  t9;
    logic [8:0]  cb9;
    logic [15:0] w;
    logic [15:0] sx;
    logic [16:0] t17;
    logic [16:0] cb17;
    logic        cin;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
    logic        wr;
    logic [15:0] res;
    a    = r.operand_a[7:0];
    b    = r.operand_b[7:0];
    mask = 8'h01 << r.bit_index;
    z    = r.zero_in;
    n    = r.sub_in;
    h    = r.half_in;
    c    = r.carry_in;
    wr   = 1'b1;
    res  = '0;
    case (r.cmd)
      OP_ADD, OP_ADC: begin
        cin = (r.cmd == OP_ADC) ? c : 1'b0;
        t9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        cb9 = {1'b0, a} ^ {1'b0, b} ^ t9;
        res = {8'h00, t9[7:0]};
        z = (t9[7:0] == 8'h00); n = 1'b0; h = cb9[4]; c = cb9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cin = (r.cmd == OP_SBC) ? c : 1'b0;
        t9  = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        cb9 = {1'b0, a} ^ {1'b0, b} ^ t9;
        res = {8'h00, t9[7:0]};
        z = (t9[7:0] == 8'h00); n = 1'b1; h = cb9[4]; c = cb9[8];
        if (r.cmd == OP_CP) begin
          res = '0;
          wr  = 1'b0;
        end
      end
      OP_AND: begin
        res = {8'h00, a & b}; z = (res == 16'h0); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_OR: begin
        res = {8'h00, a | b}; z = (res == 16'h0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_XOR: begin
        res = {8'h00, a ^ b}; z = (res == 16'h0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC: begin
        res = {8'h00, a + 8'h01}; z = (res == 16'h0); n = 1'b0; h = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        res = {8'h00, a - 8'h01}; z = (res == 16'h0); n = 1'b1; h = (a[3:0] == 4'h0);
      end
      OP_SWAP: begin
        res = {8'h00, a[3:0], a[7:4]};
        z = (res == 16'h0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_DAA: begin
        w = {8'h00, a};
        if (!n) begin
          if (h || (w[3:0] > 4'd9)) w = w + 16'h0006;
          if (c || (w > 16'h009F)) w = w + 16'h0060;
        end else begin
          if (h) w = {8'h00, w[7:0] - 8'h06};
          if (c) w = w - 16'h0060;
        end
        c   = c | w[8];
        res = {8'h00, w[7:0]};
        z = (res == 16'h0); h = 1'b0;
      end
      OP_CPL: begin
        res = {8'h00, ~a}; n = 1'b1; h = 1'b1;
      end
      OP_CCF: begin
        wr = 1'b0; n = 1'b0; h = 1'b0; c = ~c;
      end
      OP_SCF: begin
        wr = 1'b0; n = 1'b0; h = 1'b0; c = 1'b1;
      end
      OP_RLCA, OP_RLC: begin
        res = {8'h00, a[6:0], a[7]}; c = a[7];
        z = (r.cmd == OP_RLC) ? (res == 16'h0) : 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RLA, OP_RL: begin
        res = {8'h00, a[6:0], c}; c = a[7];
        z = (r.cmd == OP_RL) ? (res == 16'h0) : 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RRCA, OP_RRC: begin
        res = {8'h00, a[0], a[7:1]}; c = a[0];
        z = (r.cmd == OP_RRC) ? (res == 16'h0) : 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RRA, OP_RR: begin
        res = {8'h00, c, a[7:1]}; c = a[0];
        z = (r.cmd == OP_RR) ? (res == 16'h0) : 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_SLA: begin
        res = {8'h00, a[6:0], 1'b0}; c = a[7];
        z = (res == 16'h0); n = 1'b0; h = 1'b0;
      end
      OP_SRA: begin
        res = {8'h00, a[7], a[7:1]}; c = a[0];
        z = (res == 16'h0); n = 1'b0; h = 1'b0;
      end
      OP_SRL: begin
        res = {8'h00, 1'b0, a[7:1]}; c = a[0];
        z = (res == 16'h0); n = 1'b0; h = 1'b0;
      end
      OP_BIT: begin
        wr = 1'b0; z = ((a & mask) == 8'h00); n = 1'b0; h = 1'b1;
      end
      OP_SET: res = {8'h00, a | mask};
      OP_RES: res = {8'h00, a & ~mask};
      OP_ADD16: begin
        t17  = {1'b0, r.operand_a} + {1'b0, r.operand_b};
        cb17 = {1'b0, r.operand_a} ^ {1'b0, r.operand_b} ^ t17;
        res  = t17[15:0];
        n = 1'b0; h = cb17[12]; c = cb17[16];
      end
      OP_ADD_SP: begin
        sx  = {{8{b[7]}}, b};
        res = r.operand_a + sx;
        w   = r.operand_a ^ sx ^ res;
        z = 1'b0; n = 1'b0; h = w[4]; c = w[8];
      end
      OP_INC16: res = r.operand_a + 16'h0001;
      OP_DEC16: res = r.operand_a - 16'h0001;
      default:  wr = 1'b0;
    endcase
    o.result        = res;
    o.writes_result = wr;
    o.zero_out      = z;
    o.sub_out       = n;
    o.half_out      = h;
    o.carry_out     = c;
    return o;
  endfunction

  function automatic alu_req_t make_req(input logic [5:0] cmd, input logic [15:0] a,
                                        input logic [15:0] b, input logic [2:0] bi,
                                        input logic [3:0] znhc);
    alu_req_t r;
    r.cmd       = cmd;
    r.operand_a = a;
    r.operand_b = b;
    r.bit_index = bi;
    {r.zero_in, r.sub_in, r.half_in, r.carry_in} = znhc;
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(9))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w[7:0] = 8'hFF;
      3: w[7:0] = 8'h80;
      4: w[7:0] = 8'h0F;
      5: w[11:0] = 12'hFFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic alu_req_t rand_req();
    logic [5:0] cmd;
    if ($urandom_range(99) < 92) cmd = 6'($urandom_range(32));
    else cmd = 6'($urandom_range(63, 33));
    return make_req(cmd, pick_word(), pick_word(), 3'($urandom), 4'($urandom));
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("ERROR %0t: %s got %h, expected %h", $realtime, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is accepted.
  task automatic send_beat(input alu_req_t req);
    if (!no_idle) begin
      while ($urandom_range(99) < 34) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_beat  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_every_op();
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i <= 33; i++) begin
      a = (i % 2) ? 16'hFFFF : 16'h0000;
      b = (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h0080);
      send_beat(make_req(6'(i), a, b, 3'(i), 4'(i)));
    end
    send_beat(make_req(6'd63, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF));
  endtask

  task automatic test_special_cases();
    send_beat(make_req(OP_CP, 16'h1234, 16'h0034, 3'd0, 4'h0));
    send_beat(make_req(OP_BIT, 16'h0080, 16'h0000, 3'd7, 4'h0));
    send_beat(make_req(OP_BIT, 16'h007F, 16'h0000, 3'd7, 4'h1));
    send_beat(make_req(OP_CCF, 16'h00FF, 16'h00FF, 3'd0, 4'hF));
    send_beat(make_req(OP_SCF, 16'h00FF, 16'h00FF, 3'd0, 4'h6));
    send_beat(make_req(OP_RLCA, 16'h0000, 16'h0000, 3'd0, 4'h8));
    send_beat(make_req(OP_RRA, 16'h0001, 16'h0000, 3'd0, 4'h8));
    send_beat(make_req(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0));
    send_beat(make_req(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h3));
    send_beat(make_req(OP_DAA, 16'h00FA, 16'h0000, 3'd0, 4'h7));
    send_beat(make_req(OP_DAA, 16'h0005, 16'h0000, 3'd0, 4'h6));
    send_beat(make_req(OP_ADD_SP, 16'hFFFF, 16'h0001, 3'd0, 4'h8));
    send_beat(make_req(OP_ADD_SP, 16'h0000, 16'hFF80, 3'd0, 4'hF));
    send_beat(make_req(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8));
    send_beat(make_req(OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'hF));
    send_beat(make_req(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h0));
    send_beat(make_req(6'd50, 16'hA5A5, 16'h5A5A, 3'd5, 4'hA));
  endtask

  task automatic test_random_ops(input int count);
    repeat (count) send_beat(rand_req());
  endtask

  task automatic test_full_rate(input int count);
    no_idle = 1'b1;
    repeat (count) send_beat(rand_req());
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall(input int count);
    stall_req++;
    repeat (count) send_beat(rand_req());
  endtask

  task automatic test_sender_pause(input int count);
    repeat (count) send_beat(rand_req());
    wait_drained();
    repeat (count) send_beat(rand_req());
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = LongStall;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) result_q.push_back(alu_compute(in_beat));
  end

  always @(posedge clk) begin : check_results
    alu_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat, result", out_beat.result, 16'h0);
      end else begin
        want = result_q.pop_front();
        if (out_beat.result !== want.result)
          report_mismatch("result", out_beat.result, want.result);
        if (out_beat.writes_result !== want.writes_result)
          report_mismatch("writes_result", 16'(out_beat.writes_result), 16'(want.writes_result));
        if (out_beat.zero_out !== want.zero_out)
          report_mismatch("zero_out", 16'(out_beat.zero_out), 16'(want.zero_out));
        if (out_beat.sub_out !== want.sub_out)
          report_mismatch("sub_out", 16'(out_beat.sub_out), 16'(want.sub_out));
        if (out_beat.half_out !== want.half_out)
          report_mismatch("half_out", 16'(out_beat.half_out), 16'(want.half_out));
        if (out_beat.carry_out !== want.carry_out)
          report_mismatch("carry_out", 16'(out_beat.carry_out), 16'(want.carry_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_every_op();
    test_special_cases();
    test_random_ops(560);
    test_full_rate(120);
    test_output_stall(60);
    test_sender_pause(30);
    wait_drained();
    repeat (DrainTail) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
